// File: rtl/core/dsa_pkg.sv
// Shared types, constants and helpers for the disk sector allocator.
package dsa_pkg;

  // Geometry defaults
  localparam int DSA_NUM_TRACKS  = 35;
  localparam int DSA_MAX_SECTORS = 21;
  localparam int DSA_DIR_TRACK   = 18;

  // Fixed field widths
  localparam int TRACK_W = 6;
  localparam int SECT_W  = 5;
  localparam int CNT_W   = 5;
  localparam int CMD_W   = 3;
  localparam int IL_W    = 5;
  localparam int POS_W   = 6;   // holds sector + interleave before the reduction

  // Zone boundaries (last track of each zone) and sectors per zone
  localparam logic [TRACK_W-1:0] ZONE1_LAST = 6'd17;
  localparam logic [TRACK_W-1:0] ZONE2_LAST = 6'd24;
  localparam logic [TRACK_W-1:0] ZONE3_LAST = 6'd30;
  localparam logic [CNT_W-1:0]   ZONE1_LEN  = 5'd21;
  localparam logic [CNT_W-1:0]   ZONE2_LEN  = 5'd19;
  localparam logic [CNT_W-1:0]   ZONE3_LEN  = 5'd18;
  localparam logic [CNT_W-1:0]   ZONE4_LEN  = 5'd17;

  // Interleave: reset value and the point above which scans descend
  localparam logic [IL_W-1:0] IL_RESET       = 5'd10;
  localparam logic [IL_W-1:0] IL_DESCEND_MAX = 5'd10;

  // Sectors reserved on the directory track at reset
  localparam logic [CNT_W-1:0] DIR_RESERVED = 5'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_FIRST = 3'd0,
    CMD_NEXT  = 3'd1,
    CMD_USED  = 3'd2,
    CMD_FREE  = 3'd3,
    CMD_QUERY = 3'd4
  } dsa_op_t;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_HIT,
    RES_QUERY
  } dsa_res_t;

  // Controller to datapath
  typedef struct packed {
    logic     ld_in;      // capture the input beat
    logic     trk_first;  // track pointer to 1
    logic     trk_inc;    // next track
    logic     rd;         // read map entry of the current track
    logic     ld_ent;     // take the read entry into the work registers
    logic     pick;       // sector pointer from the read entry's free bits
    logic     pos_sum;    // sector pointer plus interleave
    logic     pos_sub;    // sector pointer minus track length
    logic     pos_step;   // one sector along the scan direction
    logic     wr;         // commit a mark
    logic     out_ld;     // load the result register
    dsa_res_t res;        // kind of result to load
  } dsa_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic             trk_ok;
    logic             sec_ok;
    logic             trk_past;
    logic             trk_dir;
    logic             rd_any;
    logic             pos_ge_n;
    logic             bit_free;
    logic             step_last;
    logic             slot_free;
  } dsa_sts_t;

  // Sectors on a track, capped at the configured maximum
  function automatic logic [CNT_W-1:0] dsa_track_len(input logic [TRACK_W-1:0] t,
                                                      input int unsigned max_s);
    logic [CNT_W-1:0] n;
    if (t <= ZONE1_LAST) begin
      n = ZONE1_LEN;
    end else if (t <= ZONE2_LAST) begin
      n = ZONE2_LEN;
    end else if (t <= ZONE3_LAST) begin
      n = ZONE3_LEN;
    end else begin
      n = ZONE4_LEN;
    end
    if (int'(n) > int'(max_s)) begin
      n = CNT_W'(max_s);
    end
    return n;
  endfunction

endpackage

// File: rtl/core/dsa_if.sv
// Handshake channels of the disk sector allocator: command in, result out, config write.
interface dsa_in_if
  import dsa_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [TRACK_W-1:0] track_in;
  logic [SECT_W-1:0]  sector_in;

  modport source (output valid, command, track_in, sector_in, input ready);
  modport sink   (input valid, command, track_in, sector_in, output ready);
endinterface

interface dsa_out_if
  import dsa_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic               found;
  logic [TRACK_W-1:0] result_track;
  logic [SECT_W-1:0]  result_sector;
  logic [CNT_W-1:0]   track_free_count;

  modport source (output valid, found, result_track, result_sector, track_free_count,
                  input ready);
  modport sink   (input valid, found, result_track, result_sector, track_free_count,
                  output ready);
endinterface

interface dsa_cfg_if
  import dsa_pkg::*;
  ();
  logic            valid;
  logic            ready;
  logic [IL_W-1:0] interleave_step;

  modport source (output valid, interleave_step, input ready);
  modport sink   (input valid, interleave_step, output ready);
endinterface

// File: rtl/core/dsa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module dsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/dsa_dp.sv
// Datapath: map storage, track and sector pointers, interleave, result register.
module dsa_dp
  import dsa_pkg::*;
#(
  parameter int NUM_TRACKS  = DSA_NUM_TRACKS,
  parameter int MAX_SECTORS = DSA_MAX_SECTORS,
  parameter int DIR_TRACK   = DSA_DIR_TRACK
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dsa_cmd_t           cmd,
  output dsa_sts_t           sts,
  // input beat payload
  input  logic [CMD_W-1:0]   in_command,
  input  logic [TRACK_W-1:0] in_track,
  input  logic [SECT_W-1:0]  in_sector,
  // config write
  input  logic               cfg_we,
  input  logic [IL_W-1:0]    cfg_data,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_found,
  output logic [TRACK_W-1:0] out_track,
  output logic [SECT_W-1:0]  out_sector,
  output logic [CNT_W-1:0]   out_count
);

  localparam int MAP_W = MAX_SECTORS;
  localparam int ENT_W = MAP_W + CNT_W;
  localparam int AW    = (NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 1;

  // work registers
  logic [IL_W-1:0]    il_r;
  logic [CMD_W-1:0]   cmd_r;
  logic [TRACK_W-1:0] trk_r;
  logic [POS_W-1:0]   pos_r;
  logic [CNT_W-1:0]   stp_r;
  logic [MAP_W-1:0]   map_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [NUM_TRACKS-1:0] vld_r;
  logic               rd_vld_r;
  logic [TRACK_W-1:0] rd_trk_r;

  // result register
  logic               out_valid_r;
  logic               out_found_r;
  logic [TRACK_W-1:0] out_trk_r;
  logic [SECT_W-1:0]  out_sec_r;
  logic [CNT_W-1:0]   out_cnt_r;

  logic [AW-1:0]      addr;
  logic [ENT_W-1:0]   ram_q;
  logic [ENT_W-1:0]   wr_ent;
  logic [CNT_W-1:0]   n_cur;
  logic [POS_W-1:0]   n_pos;
  logic [CNT_W-1:0]   n_rd;
  logic [MAP_W-1:0]   dflt_map;
  logic [CNT_W-1:0]   dflt_cnt;
  logic [MAP_W-1:0]   rd_map;
  logic [CNT_W-1:0]   rd_cnt;
  logic               bit_free;
  logic               down;
  logic               pick_down;
  logic [POS_W-1:0]   pick_lo;
  logic [POS_W-1:0]   pick_hi;
  logic [POS_W-1:0]   pick_pos;
  logic [POS_W-1:0]   step_pos;
  logic [MAP_W-1:0]   new_map;
  logic [CNT_W-1:0]   new_cnt;
  logic               mark_used;
  logic               trk_past;
  logic               trk_ok;

  assign addr     = AW'(trk_r - TRACK_W'(1));
  assign n_cur    = dsa_track_len(trk_r, MAX_SECTORS);
  assign n_pos    = POS_W'(n_cur);
  assign trk_past = trk_r > TRACK_W'(NUM_TRACKS);
  assign trk_ok   = (trk_r != '0) && !trk_past;
  assign bit_free = |(map_r & (MAP_W'(1) << pos_r));
  assign down     = il_r > IL_DESCEND_MAX;
  // the free-bit pick descends only for search first; the higher-track scan always ascends
  assign pick_down = down && (cmd_r == CMD_FIRST);

  // reset contents of the entry just read, for tracks never written
  assign n_rd = dsa_track_len(rd_trk_r, MAX_SECTORS);
  always_comb begin
    for (int i = 0; i < MAP_W; i++) begin
      dflt_map[i] = (i < int'(n_rd));
    end
    dflt_cnt = n_rd;
    if (rd_trk_r == TRACK_W'(DIR_TRACK)) begin
      dflt_map[1:0] = 2'b00;
      dflt_cnt      = n_rd - DIR_RESERVED;
    end
  end

  assign rd_map = rd_vld_r ? ram_q[MAP_W-1:0]       : dflt_map;
  assign rd_cnt = rd_vld_r ? ram_q[ENT_W-1:MAP_W]   : dflt_cnt;

  // free sector pick within one track
  always_comb begin
    pick_lo = '0;
    pick_hi = '0;
    for (int i = MAP_W - 1; i >= 0; i--) begin
      if (rd_map[i]) begin
        pick_lo = POS_W'(i);
      end
    end
    for (int i = 0; i < MAP_W; i++) begin
      if (rd_map[i]) begin
        pick_hi = POS_W'(i);
      end
    end
    pick_pos = (pick_down && !rd_map[0]) ? pick_hi : pick_lo;
  end

  // one step around the track with wrap
  always_comb begin
    if (down) begin
      step_pos = (pos_r == '0) ? n_pos - POS_W'(1) : pos_r - POS_W'(1);
    end else begin
      step_pos = (pos_r + POS_W'(1) >= n_pos) ? '0 : pos_r + POS_W'(1);
    end
  end

  // mark update; the count moves only when the bit flips
  assign mark_used = (cmd_r == CMD_USED);
  always_comb begin
    new_map = map_r;
    new_cnt = cnt_r;
    if (mark_used) begin
      new_map = map_r & ~(MAP_W'(1) << pos_r);
      if (bit_free) begin
        new_cnt = cnt_r - CNT_W'(1);
      end
    end else begin
      new_map = map_r | (MAP_W'(1) << pos_r);
      if (!bit_free) begin
        new_cnt = cnt_r + CNT_W'(1);
      end
    end
  end
  assign wr_ent = {new_cnt, new_map};

  dsa_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_TRACKS)
  ) u_map_ram (
    .clk   (clk),
    .we    (cmd.wr),
    .waddr (addr),
    .wdata (wr_ent),
    .re    (cmd.rd),
    .raddr (addr),
    .rdata (ram_q)
  );

  // control registers: interleave, entry valid bits, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      il_r        <= IL_RESET;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        il_r <= cfg_data;
      end
      if (cmd.wr) begin
        vld_r[addr] <= 1'b1;
      end
      if (cmd.out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // pointers and work registers
  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      cmd_r <= in_command;
      trk_r <= in_track;
      pos_r <= POS_W'(in_sector);
      stp_r <= '0;
    end
    if (cmd.trk_first) begin
      trk_r <= TRACK_W'(1);
    end else if (cmd.trk_inc) begin
      trk_r <= trk_r + TRACK_W'(1);
    end
    if (cmd.rd) begin
      rd_vld_r <= vld_r[addr];
      rd_trk_r <= trk_r;
    end
    if (cmd.ld_ent) begin
      map_r <= rd_map;
      cnt_r <= rd_cnt;
    end
    if (cmd.pick) begin
      pos_r <= pick_pos;
    end else if (cmd.pos_sum) begin
      pos_r <= pos_r + POS_W'(il_r);
    end else if (cmd.pos_sub) begin
      pos_r <= pos_r - n_pos;
    end else if (cmd.pos_step) begin
      pos_r <= step_pos;
      stp_r <= stp_r + CNT_W'(1);
    end
    if (cmd.wr) begin
      map_r <= new_map;
      cnt_r <= new_cnt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      case (cmd.res)
        RES_HIT: begin
          out_found_r <= 1'b1;
          out_trk_r   <= trk_r;
          out_sec_r   <= SECT_W'(pos_r);
          out_cnt_r   <= cnt_r;
        end
        RES_QUERY: begin
          out_found_r <= bit_free;
          out_trk_r   <= trk_r;
          out_sec_r   <= SECT_W'(pos_r);
          out_cnt_r   <= cnt_r;
        end
        default: begin
          out_found_r <= 1'b0;
          out_trk_r   <= '0;
          out_sec_r   <= '0;
          out_cnt_r   <= '0;
        end
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_found  = out_found_r;
  assign out_track  = out_trk_r;
  assign out_sector = out_sec_r;
  assign out_count  = out_cnt_r;

  // status to the controller
  always_comb begin
    sts.op        = cmd_r;
    sts.trk_ok    = trk_ok;
    sts.sec_ok    = pos_r < n_pos;
    sts.trk_past  = trk_past;
    sts.trk_dir   = trk_r == TRACK_W'(DIR_TRACK);
    sts.rd_any    = |rd_map;
    sts.pos_ge_n  = pos_r >= n_pos;
    sts.bit_free  = bit_free;
    sts.step_last = stp_r == (n_cur - CNT_W'(1));
    sts.slot_free = !out_valid_r || out_ready;
  end

  // a mark only ever commits to an addressed sector that exists
  a_wr_addr: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |-> trk_ok && (pos_r < n_pos))
    else $error("mark committed to an invalid address");

  // stepping around a track keeps the pointer inside it
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pos_step |=> pos_r < n_pos)
    else $error("sector pointer left the track");

  // a result without a track carries nothing else
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_trk_r == '0) |-> !out_found_r && (out_cnt_r == '0))
    else $error("empty result with found or count set");

endmodule

// File: rtl/core/dsa_ctrl.sv
// Controller: sequences reads, searches, marks and the result hand-off.
module dsa_ctrl
  import dsa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dsa_sts_t sts,
  output dsa_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_SC_CHK,
    S_SC_WAIT,
    S_NX_WAIT,
    S_NX_MOD,
    S_NX_CHK,
    S_MK_WAIT,
    S_MK_DO,
    S_DONE
  } state_t;

  state_t   state_r, state_nxt;
  dsa_res_t res_r, res_nxt;

  assign in_ready = (state_r == S_IDLE);

  // next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    cmd       = '0;
    cmd.res   = res_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_in = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts.op) inside
          CMD_FIRST: begin
            cmd.trk_first = 1'b1;
            state_nxt     = S_SC_CHK;
          end
          CMD_NEXT: begin
            if (sts.trk_ok) begin
              cmd.rd      = 1'b1;
              cmd.pos_sum = 1'b1;
              state_nxt   = S_NX_WAIT;
            end else begin
              res_nxt   = RES_NONE;
              state_nxt = S_DONE;
            end
          end
          CMD_USED, CMD_FREE, CMD_QUERY: begin
            if (sts.trk_ok && sts.sec_ok) begin
              cmd.rd    = 1'b1;
              state_nxt = S_MK_WAIT;
            end else begin
              res_nxt   = RES_NONE;
              state_nxt = S_DONE;
            end
          end
          default: begin
            res_nxt   = RES_NONE;
            state_nxt = S_DONE;
          end
        endcase
      end
      // track scan: skip the directory track, stop past the last track
      S_SC_CHK: begin
        if (sts.trk_past) begin
          res_nxt   = RES_NONE;
          state_nxt = S_DONE;
        end else if (sts.trk_dir) begin
          cmd.trk_inc = 1'b1;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = S_SC_WAIT;
        end
      end
      S_SC_WAIT: begin
        cmd.ld_ent = 1'b1;
        if (sts.rd_any) begin
          cmd.pick  = 1'b1;
          res_nxt   = RES_HIT;
          state_nxt = S_DONE;
        end else begin
          cmd.trk_inc = 1'b1;
          state_nxt   = S_SC_CHK;
        end
      end
      // search next: reduce, then walk the track, then scan upward
      S_NX_WAIT: begin
        cmd.ld_ent = 1'b1;
        state_nxt  = S_NX_MOD;
      end
      S_NX_MOD: begin
        if (sts.pos_ge_n) begin
          cmd.pos_sub = 1'b1;
        end else begin
          state_nxt = S_NX_CHK;
        end
      end
      S_NX_CHK: begin
        if (sts.bit_free) begin
          res_nxt   = RES_HIT;
          state_nxt = S_DONE;
        end else if (sts.step_last) begin
          state_nxt = S_SC_CHK;
        end else begin
          cmd.pos_step = 1'b1;
        end
      end
      // marks and query
      S_MK_WAIT: begin
        cmd.ld_ent = 1'b1;
        state_nxt  = S_MK_DO;
      end
      S_MK_DO: begin
        if (sts.op == CMD_QUERY) begin
          res_nxt = RES_QUERY;
        end else begin
          cmd.wr  = 1'b1;
          res_nxt = RES_HIT;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.slot_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered result kind
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      res_r   <= RES_NONE;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
    end
  end

  // one beat in flight at a time
  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat accepted while busy");

endmodule

// File: rtl/core/disk_sector_allocator.sv
// Top level of the disk sector allocator: controller, datapath and channel wiring.
//
//  channel  dir  beat contents                                        handshake
//  in_bus   in   command, track_in, sector_in                         valid/ready
//  out_bus  out  found, result_track, result_sector, track_free_count valid/ready
//  cfg_bus  in   interleave_step                                      valid/ready
//
// Mark and query: the accepted beat passes through dispatch, map read and mark states
// before the result register loads; the next beat is taken once the controller is idle.
// Search: each track scanned is read from the map RAM, then evaluated; the directory
// track is skipped without a read. Search next reduces, then walks sector by sector.
// One command is worked on at a time; the next is accepted while a result waits.
// Synchronous active-low reset; map entries read their reset contents until
// first written. A stalled result holds in the output register; cfg is always ready.
module disk_sector_allocator
  import dsa_pkg::*;
#(
  parameter int NUM_TRACKS  = DSA_NUM_TRACKS,
  parameter int MAX_SECTORS = DSA_MAX_SECTORS,
  parameter int DIR_TRACK   = DSA_DIR_TRACK
) (
  input logic      clk,
  input logic      rst_n,
  dsa_in_if.sink   in_bus,
  dsa_out_if.source out_bus,
  dsa_cfg_if.sink  cfg_bus
);

  dsa_cmd_t cmd;
  dsa_sts_t sts;

  assign cfg_bus.ready = 1'b1;

  dsa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dsa_dp #(
    .NUM_TRACKS  (NUM_TRACKS),
    .MAX_SECTORS (MAX_SECTORS),
    .DIR_TRACK   (DIR_TRACK)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_command (in_bus.command),
    .in_track   (in_bus.track_in),
    .in_sector  (in_bus.sector_in),
    .cfg_we     (cfg_bus.valid),
    .cfg_data   (cfg_bus.interleave_step),
    .out_valid  (out_bus.valid),
    .out_ready  (out_bus.ready),
    .out_found  (out_bus.found),
    .out_track  (out_bus.result_track),
    .out_sector (out_bus.result_sector),
    .out_count  (out_bus.track_free_count)
  );

endmodule

// File: tb/tb_disk_sector_allocator.sv
// Self-checking testbench for the disk sector allocator: directed rows, then random traffic.
module tb_disk_sector_allocator;
  import dsa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Reserved command codes, nothing happens for these
  localparam logic [CMD_W-1:0] OP_RSVD_LO = 3'd5;
  localparam logic [CMD_W-1:0] OP_RSVD_HI = 3'd7;

  // Cycles without any beat on any channel before the run is declared hung
  localparam int HANG_LIMIT   = 4000;
  localparam int LONG_HOLD    = 400;
  localparam int TAIL_CYCLES  = 200;
  localparam int REPORT_LINES = 100;

  typedef struct packed {
    logic               found;
    logic [TRACK_W-1:0] trk;
    logic [SECT_W-1:0]  sec;
    logic [CNT_W-1:0]   cnt;
  } alloc_res_t;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

  // One directed row; for ROW_CFG the sector field carries the interleave value
  typedef struct packed {
    row_kind_t          kind;
    logic [CMD_W-1:0]   cmd;
    logic [TRACK_W-1:0] trk;
    logic [SECT_W-1:0]  sec;
    bit                 typed;
    alloc_res_t         res;
  } dir_row_t;

  logic clk;
  logic rst_n;

  dsa_in_if  in_bus ();
  dsa_out_if out_bus ();
  dsa_cfg_if cfg_bus ();

  disk_sector_allocator i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  // Clock, 12 ns period
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow allocation map and interleave
  logic [DSA_MAX_SECTORS-1:0] bam_free  [1:DSA_NUM_TRACKS];
  logic [CNT_W-1:0]           bam_count [1:DSA_NUM_TRACKS];
  logic [IL_W-1:0]            ilv;

  alloc_res_t expected_res_q [$];
  alloc_res_t last_seen;
  bit         pin_typed;
  alloc_res_t pin_res;
  int         mismatches;
  int         beat_gap;
  int         tx_idle_pct;
  int         rx_stall_pct;
  int         hold_req;

  // Zoned geometry
  function automatic int sectors_on(input int t);
    if (t <= 17) return 21;
    if (t <= 24) return 19;
    if (t <= 30) return 18;
    return 17;
  endfunction

  // Ascending scan from sector 0 on tracks t0 and up, directory track skipped
  function automatic bit scan_up_from(input int t0, output int ft, output int fs);
    int t;
    int s;
    ft = 0;
    fs = 0;
    for (t = t0; t <= DSA_NUM_TRACKS; t++) begin
      if (t != DSA_DIR_TRACK) begin
        for (s = 0; s < sectors_on(t); s++) begin
          if (bam_free[t][s]) begin
            ft = t;
            fs = s;
            return 1'b1;
          end
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic bit first_free(input bit down, output int ft, output int fs);
    int t;
    int s;
    int c;
    int n;
    ft = 0;
    fs = 0;
    if (!down) return scan_up_from(1, ft, fs);
    // descending: 0, n-1, n-2, ... 1
    for (t = 1; t <= DSA_NUM_TRACKS; t++) begin
      if (t != DSA_DIR_TRACK) begin
        n = sectors_on(t);
        s = 0;
        for (c = 0; c < n; c++) begin
          if (bam_free[t][s]) begin
            ft = t;
            fs = s;
            return 1'b1;
          end
          s = (s == 0) ? n - 1 : s - 1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic bit next_free(input int t, input int sec, input bit down,
                                   output int ft, output int fs);
    int n;
    int p;
    int c;
    n = sectors_on(t);
    p = (sec + int'(ilv)) % n;
    ft = t;
    fs = p;
    if (bam_free[t][p]) return 1'b1;
    // walk the same track one sector at a time
    for (c = 0; c < n; c++) begin
      if (down) p = (p == 0) ? n - 1 : p - 1;
      else p = (p + 1 >= n) ? 0 : p + 1;
      if (bam_free[t][p]) begin
        fs = p;
        return 1'b1;
      end
    end
    return scan_up_from(t, ft, fs);
  endfunction

  function automatic alloc_res_t hit_at(input int t, input int s);
    alloc_res_t r;
    r.found = 1'b1;
    r.trk   = TRACK_W'(t);
    r.sec   = SECT_W'(s);
    r.cnt   = bam_count[t];
    return r;
  endfunction

  // Expected result of one command; updates the shadow map
  function automatic alloc_res_t predict_alloc(input logic [CMD_W-1:0] cmd,
                                               input logic [TRACK_W-1:0] trk,
                                               input logic [SECT_W-1:0] sec);
    alloc_res_t r;
    int  t;
    int  s;
    int  ft;
    int  fs;
    bit  down;
    bit  addr_ok;
    r = '0;
    t = int'(trk);
    s = int'(sec);
    down = (ilv > IL_DESCEND_MAX);
    addr_ok = (t >= 1) && (t <= DSA_NUM_TRACKS) && (s < sectors_on(t));
    case (cmd)
      CMD_FIRST: begin
        if (first_free(down, ft, fs)) r = hit_at(ft, fs);
      end
      CMD_NEXT: begin
        if (t >= 1 && t <= DSA_NUM_TRACKS && next_free(t, s, down, ft, fs)) r = hit_at(ft, fs);
      end
      CMD_USED: begin
        if (addr_ok) begin
          if (bam_free[t][s]) begin
            bam_free[t][s] = 1'b0;
            bam_count[t]   = bam_count[t] - 1'b1;
          end
          r = hit_at(t, s);
        end
      end
      CMD_FREE: begin
        if (addr_ok) begin
          if (!bam_free[t][s]) begin
            bam_free[t][s] = 1'b1;
            bam_count[t]   = bam_count[t] + 1'b1;
          end
          r = hit_at(t, s);
        end
      end
      CMD_QUERY: begin
        if (addr_ok) begin
          r = hit_at(t, s);
          r.found = bam_free[t][s];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < REPORT_LINES) $display("[%0t] %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_result(input alloc_res_t got);
    alloc_res_t want;
    if (expected_res_q.size() == 0) begin
      report_mismatch($sformatf("result beat with nothing pending: %p", got));
      return;
    end
    want = expected_res_q.pop_front();
    if (got.found !== want.found)
      report_mismatch($sformatf("found: got %b want %b", got.found, want.found));
    if (got.trk !== want.trk)
      report_mismatch($sformatf("result_track: got %0d want %0d", got.trk, want.trk));
    if (got.sec !== want.sec)
      report_mismatch($sformatf("result_sector: got %0d want %0d", got.sec, want.sec));
    if (got.cnt !== want.cnt)
      report_mismatch($sformatf("track_free_count: got %0d want %0d", got.cnt, want.cnt));
  endtask

  // Beat monitor: config, commands in, results out
  always @(posedge clk) begin : beat_mon
    alloc_res_t got;
    alloc_res_t pred;
    bit         any_beat;
    int         t;
    any_beat = 1'b0;
    if (!rst_n) begin
      for (t = 1; t <= DSA_NUM_TRACKS; t++) begin
        bam_free[t]  = DSA_MAX_SECTORS'((32'd1 << sectors_on(t)) - 1);
        bam_count[t] = CNT_W'(sectors_on(t));
      end
      bam_free[DSA_DIR_TRACK][1:0] = 2'b00;
      bam_count[DSA_DIR_TRACK]     = CNT_W'(sectors_on(DSA_DIR_TRACK) - 2);
      ilv = IL_RESET;
      expected_res_q.delete();
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        got = '{out_bus.found, out_bus.result_track, out_bus.result_sector,
                out_bus.track_free_count};
        check_result(got);
        last_seen = got;
        any_beat = 1'b1;
      end
      if (cfg_bus.valid && cfg_bus.ready) begin
        ilv = cfg_bus.interleave_step;
        any_beat = 1'b1;
      end
      if (in_bus.valid && in_bus.ready) begin
        pred = predict_alloc(in_bus.command, in_bus.track_in, in_bus.sector_in);
        expected_res_q.push_back(pin_typed ? pin_res : pred);
        any_beat = 1'b1;
      end
    end
    beat_gap <= any_beat ? 0 : beat_gap + 1;
  end

  // Hang detection
  initial begin : watchdog
    do @(posedge clk); while (beat_gap < HANG_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  // Result receiver: random stalls, plus a counted long hold on request
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  function automatic logic [TRACK_W-1:0] pick_track();
    return TRACK_W'($urandom_range(DSA_NUM_TRACKS, 1));
  endfunction

  function automatic logic [SECT_W-1:0] pick_sector(input logic [TRACK_W-1:0] t);
    return SECT_W'($urandom_range(sectors_on(t) - 1));
  endfunction

  // Offer one command beat; returns at the edge where it is taken
  task automatic offer(input logic [CMD_W-1:0] cmd, input logic [TRACK_W-1:0] trk,
                       input logic [SECT_W-1:0] sec, input bit typed = 1'b0,
                       input alloc_res_t want = '0);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    pin_typed = typed;
    pin_res   = want;
    in_bus.valid     <= 1'b1;
    in_bus.command   <= cmd;
    in_bus.track_in  <= trk;
    in_bus.sector_in <= sec;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  // Stop sending and wait for every pending result
  task automatic drain();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (expected_res_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_il(input logic [IL_W-1:0] v);
    drain();
    cfg_bus.valid           <= 1'b1;
    cfg_bus.interleave_step <= v;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // Mixed traffic: file allocation chains, frees and noise
  task automatic run_random(input int total);
    int                 sent;
    int                 k;
    int                 r;
    logic [TRACK_W-1:0] t;
    logic [SECT_W-1:0]  s;
    alloc_res_t         blk;
    sent = 0;
    while (sent < total) begin
      r = $urandom_range(99);
      if (r < 45) begin
        // allocate a file: search, take the block, search on from it
        t = pick_track();
        offer(($urandom_range(1) == 0) ? CMD_FIRST : CMD_NEXT, t, pick_sector(t));
        sent++;
        k = $urandom_range(4, 1);
        while (k > 0) begin
          drain();
          blk = last_seen;
          if (!blk.found) begin
            k = 0;
          end else begin
            offer(CMD_USED, blk.trk, blk.sec);
            offer(CMD_NEXT, blk.trk, blk.sec);
            sent += 2;
            k--;
          end
        end
      end else if (r < 65) begin
        t = pick_track();
        offer(CMD_FREE, t, pick_sector(t));
        sent++;
      end else begin
        t = ($urandom_range(9) < 8) ? pick_track() : TRACK_W'($urandom_range(63));
        s = ($urandom_range(9) < 8) ? pick_sector(t) : SECT_W'($urandom_range(31));
        offer(CMD_W'($urandom_range(7)), t, s);
        sent++;
      end
    end
  endtask

  // Main sequence
  initial begin : stimulus
    dir_row_t dir_tab [26];
    int       t;
    int       s;
    int       i;

    rst_n                   = 1'b0;
    in_bus.valid            = 1'b0;
    in_bus.command          = '0;
    in_bus.track_in         = '0;
    in_bus.sector_in        = '0;
    cfg_bus.valid           = 1'b0;
    cfg_bus.interleave_step = IL_RESET;
    pin_typed               = 1'b0;
    pin_res                 = '0;
    last_seen               = '0;
    mismatches              = 0;
    beat_gap                = 0;
    tx_idle_pct             = 0;
    rx_stall_pct            = 0;
    hold_req                = 0;

    dir_tab = '{
      '{ROW_ITEM, CMD_QUERY,  6'd18, 5'd0,  1'b1, '{1'b0, 6'd18, 5'd0,  5'd17}},
      '{ROW_ITEM, CMD_QUERY,  6'd18, 5'd1,  1'b1, '{1'b0, 6'd18, 5'd1,  5'd17}},
      '{ROW_ITEM, CMD_FIRST,  6'd0,  5'd0,  1'b1, '{1'b1, 6'd1,  5'd0,  5'd21}},
      '{ROW_ITEM, CMD_USED,   6'd1,  5'd0,  1'b1, '{1'b1, 6'd1,  5'd0,  5'd20}},
      // marking a used sector used again leaves the count alone
      '{ROW_ITEM, CMD_USED,   6'd1,  5'd0,  1'b1, '{1'b1, 6'd1,  5'd0,  5'd20}},
      '{ROW_ITEM, CMD_FIRST,  6'd0,  5'd0,  1'b1, '{1'b1, 6'd1,  5'd1,  5'd20}},
      '{ROW_ITEM, CMD_FREE,   6'd1,  5'd0,  1'b1, '{1'b1, 6'd1,  5'd0,  5'd21}},
      '{ROW_ITEM, CMD_FREE,   6'd1,  5'd0,  1'b1, '{1'b1, 6'd1,  5'd0,  5'd21}},
      // bad addresses: track 0, past the last track, sector past the zone
      '{ROW_ITEM, CMD_QUERY,  6'd0,  5'd0,  1'b1, '0},
      '{ROW_ITEM, CMD_USED,   6'd36, 5'd0,  1'b1, '0},
      '{ROW_ITEM, CMD_FREE,   6'd35, 5'd17, 1'b1, '0},
      '{ROW_ITEM, CMD_QUERY,  6'd35, 5'd16, 1'b1, '{1'b1, 6'd35, 5'd16, 5'd17}},
      '{ROW_ITEM, OP_RSVD_LO, 6'd1,  5'd0,  1'b1, '0},
      '{ROW_ITEM, OP_RSVD_HI, 6'd63, 5'd31, 1'b1, '0},
      '{ROW_ITEM, CMD_NEXT,   6'd17, 5'd20, 1'b1, '{1'b1, 6'd17, 5'd9,  5'd21}},
      // directory track as the start of search next
      '{ROW_ITEM, CMD_NEXT,   6'd18, 5'd31, 1'b1, '{1'b1, 6'd18, 5'd3,  5'd17}},
      '{ROW_ITEM, CMD_NEXT,   6'd63, 5'd5,  1'b1, '0},
      '{ROW_CFG,  CMD_FIRST,  6'd0,  5'd0,  1'b0, '0},
      '{ROW_ITEM, CMD_NEXT,   6'd5,  5'd4,  1'b1, '{1'b1, 6'd5,  5'd4,  5'd21}},
      '{ROW_CFG,  CMD_FIRST,  6'd0,  5'd31, 1'b0, '0},
      '{ROW_ITEM, CMD_USED,   6'd1,  5'd0,  1'b1, '{1'b1, 6'd1,  5'd0,  5'd20}},
      '{ROW_ITEM, CMD_FIRST,  6'd0,  5'd0,  1'b1, '{1'b1, 6'd1,  5'd20, 5'd20}},
      '{ROW_ITEM, CMD_NEXT,   6'd35, 5'd31, 1'b1, '{1'b1, 6'd35, 5'd11, 5'd17}},
      '{ROW_ITEM, CMD_USED,   6'd35, 5'd11, 1'b1, '{1'b1, 6'd35, 5'd11, 5'd16}},
      '{ROW_ITEM, CMD_NEXT,   6'd35, 5'd31, 1'b0, '0},
      '{ROW_ITEM, CMD_FREE,   6'd1,  5'd0,  1'b0, '0}
    };

    // Reset
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed rows, no idling
    for (i = 0; i < 26; i++) begin
      if (dir_tab[i].kind == ROW_CFG) write_il(dir_tab[i].sec);
      else offer(dir_tab[i].cmd, dir_tab[i].trk, dir_tab[i].sec, dir_tab[i].typed,
                 dir_tab[i].res);
    end

    // Random phases at several interleaves and idle mixes
    write_il(IL_RESET);
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    run_random(30);

    write_il(IL_DESCEND_MAX + 1'b1);
    tx_idle_pct = 75;
    rx_stall_pct = 0;
    run_random(30);

    write_il(5'd3);
    tx_idle_pct = 0;
    rx_stall_pct = 75;
    run_random(30);

    // Long receiver hold while commands keep coming
    drain();
    @(posedge clk);
    hold_req = LONG_HOLD;
    for (i = 0; i < 16; i++) begin
      t = int'(pick_track());
      offer(($urandom_range(1) == 0) ? CMD_QUERY : CMD_FIRST, TRACK_W'(t),
            pick_sector(TRACK_W'(t)));
    end

    write_il(5'd20);
    tx_idle_pct = 35;
    rx_stall_pct = 35;
    run_random(30);

    // Fill the whole disk, then search it full
    write_il(5'd1);
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    for (t = 1; t <= DSA_NUM_TRACKS; t++) begin
      for (s = 0; s < sectors_on(t); s++) offer(CMD_USED, TRACK_W'(t), SECT_W'(s));
    end
    offer(CMD_FIRST, 6'd0, 5'd0);
    offer(CMD_NEXT, 6'd1, 5'd0);
    offer(CMD_NEXT, 6'd35, 5'd16);
    write_il(5'd31);
    offer(CMD_FIRST, 6'd0, 5'd0);
    offer(CMD_NEXT, 6'd10, 5'd5);
    // a free directory sector is invisible to search first, not to search next on it
    offer(CMD_FREE, 6'd18, 5'd0);
    offer(CMD_FIRST, 6'd0, 5'd0);
    offer(CMD_NEXT, 6'd18, 5'd7);
    offer(CMD_FREE, 6'd35, 5'd16);
    offer(CMD_FIRST, 6'd0, 5'd0);
    offer(CMD_NEXT, 6'd1, 5'd0);

    write_il(5'd16);
    tx_idle_pct = 35;
    rx_stall_pct = 35;
    run_random(20);

    // Wind down
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_res_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_res_q.size()));
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/dsa_pkg.sv
rtl/core/dsa_if.sv
rtl/core/dsa_ram.sv
rtl/core/dsa_dp.sv
rtl/core/dsa_ctrl.sv
rtl/core/disk_sector_allocator.sv
tb/tb_disk_sector_allocator.sv
